FILE: sv/lbba_pkg.sv
// Shared constants and types for the label bounding box accumulator.
// No dependencies; imported by the top level.
`default_nettype none

package lbba_pkg;

  // label table size and coordinate width
  localparam int MaxLabels = 64;
  localparam int CoordW    = 10;

  // input label width and output box label width
  localparam int LabelW    = 8;
  localparam int BoxLabW   = 7;

  // table address width
  localparam int AddrW     = (MaxLabels > 1) ? $clog2(MaxLabels) : 1;

  // one entry of the box table
  typedef struct packed {
    logic [CoordW-1:0] lo_x;
    logic [CoordW-1:0] lo_y;
    logic [CoordW-1:0] lo_z;
    logic [CoordW-1:0] hi_x;
    logic [CoordW-1:0] hi_y;
    logic [CoordW-1:0] hi_z;
  } box_t;

  localparam int BoxW = $bits(box_t);

endpackage

`default_nettype wire

FILE: sv/lbba_box_ram.sv
// Simple dual-port synchronous RAM holding the box table.
// One write port, one read port with registered read data; no dependencies.
`default_nettype none

module lbba_box_ram #(
  parameter int DataW = 60,
  parameter int Depth = 64,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [DataW-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem_q [Depth];

  // write port, read port returns old data on a same-address collision
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

FILE: sv/label_bounding_box_accumulator.sv
// Per-label bounding box accumulator; uses lbba_pkg and lbba_box_ram.
// Scanning: one voxel item per cycle unless busy; read in the accept cycle, merged and
// written the next, with the previous cycle's write forwarded on a same-entry hit.
// On scan_end busy stays high for the scan_end merge and the walk over labels 1..H (H =
// highest label, 0 if none); boxes then strobe one per cycle, one empty box if none seen.
// Reset clears used bits, highest label and overflow, not the table; the receiver cannot stall.
`default_nettype none

module label_bounding_box_accumulator
  import lbba_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [CoordW-1:0] coord_x_i,
  input  wire logic [CoordW-1:0] coord_y_i,
  input  wire logic [CoordW-1:0] coord_z_i,
  input  wire logic [LabelW-1:0] label_i,
  input  wire logic              scan_end_i,
  output logic                   box_valid_o,
  output logic [BoxLabW-1:0]     box_label_o,
  output logic [CoordW-1:0]      box_min_x_o,
  output logic [CoordW-1:0]      box_min_y_o,
  output logic [CoordW-1:0]      box_min_z_o,
  output logic [CoordW-1:0]      box_max_x_o,
  output logic [CoordW-1:0]      box_max_y_o,
  output logic [CoordW-1:0]      box_max_z_o,
  output logic                   box_empty_o,
  output logic                   label_overflow_o,
  output logic                   final_box_o
);

  // accept and input decode
  logic               accept;
  logic               in_range;
  logic               in_ovf;
  logic [LabelW-1:0]  label_m1;
  logic [AddrW-1:0]   acc_addr;

  // merge stage
  logic               s1_valid_q;
  logic               s1_end_q;
  logic               s1_upd_q;
  logic               s1_ovf_q;
  logic [AddrW-1:0]   s1_addr_q;
  logic [BoxLabW-1:0] s1_label_q;
  logic [CoordW-1:0]  s1_x_q, s1_y_q, s1_z_q;

  // forwarding of the last write
  logic               lw_valid_q;
  logic [AddrW-1:0]   lw_addr_q;
  box_t               lw_data_q;

  // scan state
  logic [MaxLabels-1:0] used_q, used_d;
  logic [BoxLabW-1:0]   highest_q, highest_d;
  logic                 ovf_q, ovf_d;

  // readout walk
  logic               ro_active_q;
  logic [BoxLabW-1:0] ro_cnt_q;
  logic [BoxLabW-1:0] ro_hi_q;
  logic [BoxLabW-1:0] ro_cnt_m1;
  logic [AddrW-1:0]   ro_addr;
  logic               ro_last;

  // readout data stage
  logic               rd_valid_q;
  logic [BoxLabW-1:0] rd_label_q;
  logic               rd_used_q;
  logic               rd_last_q;
  logic               rd_ovf_q;

  // ram ports
  logic               ram_we;
  logic [AddrW-1:0]   ram_raddr;
  logic [BoxW-1:0]    ram_rdata;
  box_t               old_box;
  box_t               new_box;
  box_t               rd_box;
  logic               fwd;
  logic               s1_used;
  logic               scan_done;

  assign busy   = (s1_valid_q & s1_end_q) | ro_active_q;
  assign accept = start & ~busy;

  // label classification
  assign in_ovf   = label_i > LabelW'(MaxLabels);
  assign in_range = (label_i != '0) & ~in_ovf;
  assign label_m1 = label_i - LabelW'(1);
  assign acc_addr = label_m1[AddrW-1:0];

  assign ro_cnt_m1 = ro_cnt_q - BoxLabW'(1);
  assign ro_addr   = ro_cnt_m1[AddrW-1:0];
  assign ro_last   = ro_cnt_q == ro_hi_q;
  assign ram_raddr = ro_active_q ? ro_addr : acc_addr;

  // read-modify-write merge
  assign fwd     = lw_valid_q & (lw_addr_q == s1_addr_q);
  assign old_box = fwd ? lw_data_q : box_t'(ram_rdata);
  assign s1_used = used_q[s1_addr_q];
  assign ram_we  = s1_valid_q & s1_upd_q;

  always_comb begin
    if (s1_used) begin
      new_box.lo_x = (s1_x_q < old_box.lo_x) ? s1_x_q : old_box.lo_x;
      new_box.lo_y = (s1_y_q < old_box.lo_y) ? s1_y_q : old_box.lo_y;
      new_box.lo_z = (s1_z_q < old_box.lo_z) ? s1_z_q : old_box.lo_z;
      new_box.hi_x = (s1_x_q > old_box.hi_x) ? s1_x_q : old_box.hi_x;
      new_box.hi_y = (s1_y_q > old_box.hi_y) ? s1_y_q : old_box.hi_y;
      new_box.hi_z = (s1_z_q > old_box.hi_z) ? s1_z_q : old_box.hi_z;
    end else begin
      new_box.lo_x = s1_x_q;
      new_box.lo_y = s1_y_q;
      new_box.lo_z = s1_z_q;
      new_box.hi_x = s1_x_q;
      new_box.hi_y = s1_y_q;
      new_box.hi_z = s1_z_q;
    end
  end

  // scan state update from the merge stage
  always_comb begin
    used_d    = used_q;
    highest_d = highest_q;
    if (ram_we) begin
      used_d[s1_addr_q] = 1'b1;
      if (s1_label_q > highest_q) begin
        highest_d = s1_label_q;
      end
    end
    ovf_d = ovf_q | (s1_valid_q & s1_ovf_q);
  end

  assign scan_done = s1_valid_q & s1_end_q;

  lbba_box_ram #(
    .DataW (BoxW),
    .Depth (MaxLabels)
  ) u_box_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_addr_q),
    .wdata_i (new_box),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      lw_valid_q  <= 1'b0;
      used_q      <= '0;
      highest_q   <= '0;
      ovf_q       <= 1'b0;
      ro_active_q <= 1'b0;
      ro_cnt_q    <= '0;
      ro_hi_q     <= '0;
      rd_valid_q  <= 1'b0;
      box_valid_o <= 1'b0;
    end else begin
      s1_valid_q  <= accept;
      lw_valid_q  <= ram_we;
      used_q      <= used_d;
      highest_q   <= highest_d;
      ovf_q       <= ovf_d;
      rd_valid_q  <= 1'b0;
      box_valid_o <= rd_valid_q;
      if (scan_done) begin
        if (highest_d == '0) begin
          // nothing seen: a single empty box
          rd_valid_q <= 1'b1;
          used_q     <= '0;
          highest_q  <= '0;
          ovf_q      <= 1'b0;
        end else begin
          ro_active_q <= 1'b1;
          ro_cnt_q    <= BoxLabW'(1);
          ro_hi_q     <= highest_d;
        end
      end else if (ro_active_q) begin
        rd_valid_q <= 1'b1;
        ro_cnt_q   <= ro_cnt_q + BoxLabW'(1);
        if (ro_last) begin
          ro_active_q <= 1'b0;
          used_q      <= '0;
          highest_q   <= '0;
          ovf_q       <= 1'b0;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_end_q   <= scan_end_i;
      s1_upd_q   <= in_range;
      s1_ovf_q   <= in_ovf;
      s1_addr_q  <= acc_addr;
      s1_label_q <= label_i[BoxLabW-1:0];
      s1_x_q     <= coord_x_i;
      s1_y_q     <= coord_y_i;
      s1_z_q     <= coord_z_i;
    end
    if (ram_we) begin
      lw_addr_q <= s1_addr_q;
      lw_data_q <= new_box;
    end
    if (scan_done) begin
      rd_label_q <= '0;
      rd_used_q  <= 1'b0;
      rd_last_q  <= 1'b1;
      rd_ovf_q   <= ovf_d;
    end else if (ro_active_q) begin
      rd_label_q <= ro_cnt_q;
      rd_used_q  <= used_q[ro_addr];
      rd_last_q  <= ro_last;
      rd_ovf_q   <= ovf_q;
    end
  end

  // output register, unseen labels read as zero boxes
  assign rd_box = rd_used_q ? box_t'(ram_rdata) : '0;

  always_ff @(posedge clk_i) begin
    if (rd_valid_q) begin
      box_label_o      <= rd_label_q;
      box_min_x_o      <= rd_box.lo_x;
      box_min_y_o      <= rd_box.lo_y;
      box_min_z_o      <= rd_box.lo_z;
      box_max_x_o      <= rd_box.hi_x;
      box_max_y_o      <= rd_box.hi_y;
      box_max_z_o      <= rd_box.hi_z;
      box_empty_o      <= ~rd_used_q;
      label_overflow_o <= rd_ovf_q;
      final_box_o      <= rd_last_q;
    end
  end

endmodule

`default_nettype wire
